[rtl/rms_pkg.sv]
// Package for the robot mode supervisor: transaction payload types, state
// record, operation, mode and gait codes, and the legal transition table.
// No dependencies.
package rms_pkg;

   localparam int ModeW = 3;
   localparam int GaitW = 3;
   localparam int OpW   = 3;
   localparam int TimeW = 24;
   localparam int TickW = 20;
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;

   localparam logic [OpW-1:0] OP_REQUEST    = 3'd0;
   localparam logic [OpW-1:0] OP_TICK       = 3'd1;
   localparam logic [OpW-1:0] OP_ESTOP      = 3'd2;
   localparam logic [OpW-1:0] OP_CLEAR      = 3'd3;
   localparam logic [OpW-1:0] OP_SET_GAIT   = 3'd4;
   localparam logic [OpW-1:0] OP_NEXT_GAIT  = 3'd5;

   localparam logic [ModeW-1:0] MODE_PASSIVE   = 3'd0;
   localparam logic [ModeW-1:0] MODE_PD        = 3'd1;
   localparam logic [ModeW-1:0] MODE_STANDING  = 3'd2;
   localparam logic [ModeW-1:0] MODE_WALKING   = 3'd3;
   localparam logic [ModeW-1:0] MODE_RECOVERY  = 3'd4;
   localparam logic [ModeW-1:0] MODE_EMERGENCY = 3'd5;

   localparam logic [GaitW-1:0] GAIT_STANCE        = 3'd0;
   localparam logic [GaitW-1:0] GAIT_TROT          = 3'd1;
   localparam logic [GaitW-1:0] GAIT_STANDING_TROT = 3'd2;
   localparam logic [GaitW-1:0] GAIT_PACE          = 3'd3;
   localparam logic [GaitW-1:0] GAIT_DYNAMIC_WALK  = 3'd4;

   localparam logic [TimeW-1:0] TIME_MAX = {TimeW{1'b1}};
   localparam logic [TimeW-1:0] RECOVERY_RESET = 24'd3000000;

   localparam logic CSR_RECOVERY_DURATION = 1'b0;

   typedef struct packed {
      logic [OpW-1:0]   op;
      logic [ModeW-1:0] target_mode;
      logic [GaitW-1:0] gait_choice;
      logic [TickW-1:0] elapsed_us;
   } req_type;

   typedef struct packed {
      logic             accepted;
      logic [ModeW-1:0] mode;
      logic [ModeW-1:0] prior_mode;
      logic             mode_changed;
      logic             controller_on;
      logic [GaitW-1:0] gait;
      logic             gait_changed;
      logic             recovering;
   } rsp_type;

   typedef struct packed {
      logic [ModeW-1:0] current_mode;
      logic [ModeW-1:0] pending_mode;
      logic [ModeW-1:0] previous_mode;
      logic [TimeW-1:0] recovery_elapsed;
      logic             recovery_flag;
      logic             enable_flag;
      logic [GaitW-1:0] gait_now;
   } state_type;

   // Bit t of the entry for mode c is set when the move from c to t is legal.
   function automatic logic may_go(input logic [ModeW-1:0] from_mode,
                                   input logic [ModeW-1:0] to_mode);
      logic [7:0] row;
      case (from_mode)
         3'd0:    row = 8'h26;
         3'd1:    row = 8'h3D;
         3'd2:    row = 8'h3B;
         3'd3:    row = 8'h37;
         3'd4:    row = 8'h27;
         3'd5:    row = 8'h01;
         default: row = 8'h00;
      endcase
      return row[to_mode];
   endfunction

endpackage

[rtl/rms_csr.sv]
// Configuration register block of the robot mode supervisor: APB-style
// access to the recovery duration register.
// Depends on rms_pkg.
module rms_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rms_pkg::CsrAddrW-1:0]  paddr,
   input  logic [rms_pkg::CsrDataW-1:0]  pwdata,
   output logic [rms_pkg::CsrDataW-1:0]  prdata,
   output logic                          pready,
   output logic [rms_pkg::TimeW-1:0]     recovery_duration
);
   import rms_pkg::*;

   logic [TimeW-1:0] duration_ff;
   logic [TimeW-1:0] duration_in;
   logic             write_hit;

   assign pready    = 1'b1;
   assign write_hit = psel & penable & pwrite & (paddr[CsrAddrW-1] == CSR_RECOVERY_DURATION);

   always_comb begin
      duration_in = duration_ff;
      if (write_hit) begin
         duration_in = pwdata[TimeW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff <= RECOVERY_RESET;
      end else begin
         duration_ff <= duration_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[CsrAddrW-1] == CSR_RECOVERY_DURATION) begin
         prdata = {{(CsrDataW-TimeW){1'b0}}, duration_ff};
      end
   end

   assign recovery_duration = duration_ff;
endmodule

[rtl/rms_step.sv]
// Next-state logic of the robot mode supervisor: applies one transaction to
// the supervisor state and forms its result.
// Depends on rms_pkg.
module rms_step (
   input  rms_pkg::state_type          state_cur,
   input  rms_pkg::req_type            req,
   input  logic [rms_pkg::TimeW-1:0]   recovery_duration,
   output rms_pkg::state_type          state_nxt,
   output rms_pkg::rsp_type            rsp
);
   import rms_pkg::*;

   state_type        s;
   logic             accepted;
   logic             changed;
   logic             gait_flag;
   logic [TimeW:0]   sum;
   logic [TimeW-1:0] sat;

   always_comb begin
      s         = state_cur;
      accepted  = 1'b0;
      changed   = 1'b0;
      gait_flag = 1'b0;
      sum       = '0;
      sat       = '0;
      unique case (req.op)
         OP_REQUEST: begin
            if (req.target_mode <= MODE_EMERGENCY &&
                may_go(state_cur.current_mode, req.target_mode)) begin
               s.pending_mode = req.target_mode;
               accepted = 1'b1;
            end
         end
         OP_TICK: begin
            if (state_cur.pending_mode != state_cur.current_mode) begin
               s.previous_mode    = state_cur.current_mode;
               s.current_mode     = state_cur.pending_mode;
               s.recovery_elapsed = '0;
               s.recovery_flag    = (state_cur.pending_mode == MODE_RECOVERY);
               s.enable_flag      = (state_cur.pending_mode == MODE_STANDING) ||
                                    (state_cur.pending_mode == MODE_WALKING);
               if (state_cur.pending_mode == MODE_STANDING) begin
                  s.gait_now = GAIT_STANCE;
                  gait_flag  = 1'b1;
               end else if (state_cur.pending_mode == MODE_WALKING) begin
                  s.gait_now = GAIT_TROT;
                  gait_flag  = 1'b1;
               end
               changed = 1'b1;
            end
            if (s.current_mode == MODE_RECOVERY) begin
               sum = {1'b0, s.recovery_elapsed} + {{(TimeW+1-TickW){1'b0}}, req.elapsed_us};
               sat = sum[TimeW] ? TIME_MAX : sum[TimeW-1:0];
               s.recovery_elapsed = sat;
               if (sat >= recovery_duration && may_go(s.current_mode, MODE_PD)) begin
                  s.pending_mode = MODE_PD;
               end
            end
         end
         OP_ESTOP: begin
            s.pending_mode     = MODE_EMERGENCY;
            s.previous_mode    = state_cur.current_mode;
            s.current_mode     = MODE_EMERGENCY;
            s.recovery_elapsed = '0;
            s.recovery_flag    = 1'b0;
            s.enable_flag      = 1'b0;
            changed = 1'b1;
         end
         OP_CLEAR: begin
            if (state_cur.current_mode == MODE_EMERGENCY &&
                may_go(state_cur.current_mode, MODE_PASSIVE)) begin
               s.pending_mode = MODE_PASSIVE;
               accepted = 1'b1;
            end
         end
         OP_SET_GAIT: begin
            if (state_cur.current_mode == MODE_WALKING ||
                state_cur.current_mode == MODE_STANDING) begin
               s.gait_now = req.gait_choice;
               gait_flag  = 1'b1;
               accepted   = 1'b1;
            end
         end
         OP_NEXT_GAIT: begin
            if (state_cur.current_mode == MODE_WALKING) begin
               case (state_cur.gait_now)
                  GAIT_TROT:          s.gait_now = GAIT_STANDING_TROT;
                  GAIT_STANDING_TROT: s.gait_now = GAIT_PACE;
                  GAIT_PACE:          s.gait_now = GAIT_DYNAMIC_WALK;
                  default:            s.gait_now = GAIT_TROT;
               endcase
               gait_flag = 1'b1;
               accepted  = 1'b1;
            end
         end
         default: begin
            s = state_cur;
         end
      endcase
   end

   assign state_nxt = s;

   always_comb begin
      rsp.accepted      = accepted;
      rsp.mode          = s.current_mode;
      rsp.prior_mode    = s.previous_mode;
      rsp.mode_changed  = changed;
      rsp.controller_on = s.enable_flag;
      rsp.gait          = s.gait_now;
      rsp.gait_changed  = gait_flag;
      rsp.recovering    = s.recovery_flag;
   end
endmodule

[rtl/rms_outq.sv]
// Two-entry result queue of the robot mode supervisor: holds finished
// results so that a new transaction is taken while one still waits.
// Depends on rms_pkg.
module rms_outq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rms_pkg::rsp_type  push_data,
   output logic              has_room,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rms_pkg::rsp_type  rsp_data
);
   import rms_pkg::*;

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;

   assign has_room  = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid & rsp_ready;
   assign rsp_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

[rtl/robot_mode_supervisor.sv]
// Top level of the robot mode supervisor: state registers, next-state logic,
// result queue and configuration register block.
// Depends on rms_pkg, rms_csr, rms_step and rms_outq.
//
//   Channel   Ports                               Direction  Payload
//   req       req_valid, req_ready, req_data      in         rms_pkg::req_type
//   rsp       rsp_valid, rsp_ready, rsp_data      out        rms_pkg::rsp_type
//   csr       psel, penable, pwrite, paddr, ...   in/out     recovery duration
//
// The state registers update at the accepting edge, and the result is
// written into the result queue at the same edge.
// One transaction can be accepted every cycle while the queue has room,
// set by the single next-state logic stage. A two-entry result queue keeps
// intake going while a result waits; req_ready drops only when it is full.
// Synchronous reset returns the supervisor to passive mode with stance gait.
module robot_mode_supervisor (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rms_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rms_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rms_pkg::CsrAddrW-1:0]  paddr,
   input  logic [rms_pkg::CsrDataW-1:0]  pwdata,
   output logic [rms_pkg::CsrDataW-1:0]  prdata,
   output logic                          pready
);
   import rms_pkg::*;

   state_type        state_ff;
   state_type        state_in;
   state_type        state_nxt;
   rsp_type          step_rsp;
   logic [TimeW-1:0] recovery_duration;
   logic             has_room;
   logic             take;

   assign req_ready = has_room;
   assign take      = req_valid & has_room;

   rms_csr u_csr (
      .clock             (clock),
      .reset             (reset),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .recovery_duration (recovery_duration)
   );

   rms_step u_step (
      .state_cur         (state_ff),
      .req               (req_data),
      .recovery_duration (recovery_duration),
      .state_nxt         (state_nxt),
      .rsp               (step_rsp)
   );

   always_comb begin
      state_in = state_ff;
      if (take) begin
         state_in = state_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.current_mode     <= MODE_PASSIVE;
         state_ff.pending_mode     <= MODE_PASSIVE;
         state_ff.previous_mode    <= MODE_PASSIVE;
         state_ff.recovery_elapsed <= '0;
         state_ff.recovery_flag    <= 1'b0;
         state_ff.enable_flag      <= 1'b0;
         state_ff.gait_now         <= GAIT_STANCE;
      end else begin
         state_ff <= state_in;
      end
   end

   rms_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data (step_rsp),
      .has_room  (has_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for robot_mode_supervisor: drives mode, tick, emergency and gait
// transactions, predicts every status result and compares it field by field.
// Depends on rms_pkg and the robot_mode_supervisor RTL.
module testbench;
   import rms_pkg::*;

   localparam logic [OpW-1:0]      OP_UNUSED    = 3'd7;
   localparam logic [ModeW-1:0]    MODE_INVALID = 3'd6;
   localparam logic [GaitW-1:0]    GAIT_UNNAMED = 3'd7;
   localparam logic [TickW-1:0]    TICK_MAX     = {TickW{1'b1}};
   localparam logic [CsrAddrW-1:0] DURATION_ADDR =
      CsrAddrW'(4 * int'(CSR_RECOVERY_DURATION));
   // Bit 8*from + to is set when the move between those modes is legal.
   localparam logic [63:0] LEGAL_MOVES = 64'h0000_0127_373B_3D26;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [CsrAddrW-1:0] paddr = '0;
   logic [CsrDataW-1:0] pwdata = '0;
   logic [CsrDataW-1:0] prdata;
   logic                pready;

   req_type command_queue[$];
   rsp_type expected_status[$];
   rsp_type want;
   logic    req_taken = 1'b0;
   logic    no_idle = 1'b0;
   logic    hold_done = 1'b0;
   int      hold_left = 0;
   int      results_seen = 0;
   int      mismatch_count = 0;
   int      issued = 0;

   logic [ModeW-1:0] st_mode;
   logic [ModeW-1:0] st_pending;
   logic [ModeW-1:0] st_previous;
   logic [TimeW-1:0] st_elapsed;
   logic             st_recovering;
   logic             st_enable;
   logic [GaitW-1:0] st_gait;
   logic             gait_touched;
   logic [TimeW-1:0] rec_duration = RECOVERY_RESET;

   robot_mode_supervisor u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("** robot_mode_supervisor: FAILED **");
      $finish;
   end

   function automatic logic try_request(input logic [ModeW-1:0] target);
      if (target > MODE_EMERGENCY || !LEGAL_MOVES[{st_mode, target}]) return 1'b0;
      st_pending = target;
      return 1'b1;
   endfunction

   function automatic void enter_mode(input logic [ModeW-1:0] next_mode);
      st_previous   = st_mode;
      st_mode       = next_mode;
      st_elapsed    = '0;
      st_recovering = 1'b0;
      st_enable     = 1'b0;
      if (next_mode == MODE_STANDING) begin
         st_enable    = 1'b1;
         st_gait      = GAIT_STANCE;
         gait_touched = 1'b1;
      end else if (next_mode == MODE_WALKING) begin
         st_enable    = 1'b1;
         st_gait      = GAIT_TROT;
         gait_touched = 1'b1;
      end else if (next_mode == MODE_RECOVERY) begin
         st_recovering = 1'b1;
      end
   endfunction

   function automatic rsp_type supervise(input req_type rq);
      rsp_type        r;
      logic [TimeW:0] total;
      logic           ok;
      logic           changed;
      ok           = 1'b0;
      changed      = 1'b0;
      gait_touched = 1'b0;
      case (rq.op)
         OP_REQUEST: ok = try_request(rq.target_mode);
         OP_TICK: begin
            if (st_pending != st_mode) begin
               enter_mode(st_pending);
               changed = 1'b1;
            end
            if (st_mode == MODE_RECOVERY) begin
               total = {1'b0, st_elapsed} + {{(TimeW+1-TickW){1'b0}}, rq.elapsed_us};
               st_elapsed = total[TimeW] ? TIME_MAX : total[TimeW-1:0];
               if (st_elapsed >= rec_duration) void'(try_request(MODE_PD));
            end
         end
         OP_ESTOP: begin
            st_pending = MODE_EMERGENCY;
            enter_mode(MODE_EMERGENCY);
            changed = 1'b1;
         end
         OP_CLEAR: begin
            if (st_mode == MODE_EMERGENCY) ok = try_request(MODE_PASSIVE);
         end
         OP_SET_GAIT: begin
            if (st_mode == MODE_WALKING || st_mode == MODE_STANDING) begin
               st_gait      = rq.gait_choice;
               gait_touched = 1'b1;
               ok           = 1'b1;
            end
         end
         OP_NEXT_GAIT: begin
            if (st_mode == MODE_WALKING) begin
               case (st_gait)
                  GAIT_TROT:          st_gait = GAIT_STANDING_TROT;
                  GAIT_STANDING_TROT: st_gait = GAIT_PACE;
                  GAIT_PACE:          st_gait = GAIT_DYNAMIC_WALK;
                  default:            st_gait = GAIT_TROT;
               endcase
               gait_touched = 1'b1;
               ok           = 1'b1;
            end
         end
         default: ;
      endcase
      r.accepted      = ok;
      r.mode          = st_mode;
      r.prior_mode    = st_previous;
      r.mode_changed  = changed;
      r.controller_on = st_enable;
      r.gait          = st_gait;
      r.gait_changed  = gait_touched;
      r.recovering    = st_recovering;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] got_val);
      if (got_val !== exp_val)
         report_mismatch($sformatf("result %0d field %s expected %0d, got %0d",
                                   results_seen, name, exp_val, got_val));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         st_mode       = MODE_PASSIVE;
         st_pending    = MODE_PASSIVE;
         st_previous   = MODE_PASSIVE;
         st_elapsed    = '0;
         st_recovering = 1'b0;
         st_enable     = 1'b0;
         st_gait       = GAIT_STANCE;
         gait_touched  = 1'b0;
         req_taken    <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_status.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with none expected",
                                         results_seen));
            end else begin
               want = expected_status.pop_front();
               check_field("accepted", 32'(want.accepted), 32'(rsp_data.accepted));
               check_field("mode", 32'(want.mode), 32'(rsp_data.mode));
               check_field("prior_mode", 32'(want.prior_mode), 32'(rsp_data.prior_mode));
               check_field("mode_changed", 32'(want.mode_changed),
                           32'(rsp_data.mode_changed));
               check_field("controller_on", 32'(want.controller_on),
                           32'(rsp_data.controller_on));
               check_field("gait", 32'(want.gait), 32'(rsp_data.gait));
               check_field("gait_changed", 32'(want.gait_changed),
                           32'(rsp_data.gait_changed));
               check_field("recovering", 32'(want.recovering), 32'(rsp_data.recovering));
            end
         end
         if (req_valid && req_ready) expected_status.push_back(supervise(req_data));
         req_taken <= req_valid && req_ready;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (command_queue.size() > 0 && (no_idle || $urandom_range(99) >= 27)) begin
            req_data  <= command_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The long hold-off lets the result queue fill so that req_ready drops.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && results_seen >= 300) begin
         hold_done <= 1'b1;
         hold_left <= 120;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= 27);
      end
   end

   task automatic queue_command(input logic [OpW-1:0] op, input logic [ModeW-1:0] target,
                                input logic [GaitW-1:0] gait, input logic [TickW-1:0] dt);
      req_type item;
      item.op          = op;
      item.target_mode = target;
      item.gait_choice = gait;
      item.elapsed_us  = dt;
      command_queue.push_back(item);
      if (op <= OP_NEXT_GAIT) issued++;
   endtask

   task automatic queue_op(input logic [OpW-1:0] op);
      queue_command(op, ModeW'($urandom), GaitW'($urandom), TickW'($urandom));
   endtask

   task automatic write_duration(input logic [CsrDataW-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= DURATION_ADDR;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rec_duration = value[TimeW-1:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (command_queue.size() != 0 || expected_status.size() != 0 ||
             (req_valid && !req_taken))
         @(negedge clock);
   endtask

   task automatic random_phase(input int count);
      int               goal;
      int               kind;
      int               pick;
      logic [TickW-1:0] dt;
      goal = issued + count;
      while (issued < goal) begin
         kind = $urandom_range(99);
         if (kind < 35) begin
            if ($urandom_range(3) != 0) begin
               queue_op(OP_ESTOP);
               queue_op(OP_CLEAR);
               queue_op(OP_TICK);
               queue_command(OP_REQUEST, MODE_PD, GaitW'($urandom), TickW'($urandom));
               queue_op(OP_TICK);
            end
            queue_command(OP_REQUEST, MODE_RECOVERY, GaitW'($urandom), TickW'($urandom));
            if ($urandom_range(3) == 0) begin
               repeat (20)
                  queue_command(OP_TICK, ModeW'($urandom), GaitW'($urandom), TICK_MAX);
            end else begin
               repeat ($urandom_range(1, 20)) begin
                  pick = $urandom_range(9);
                  if (pick < 3) dt = TICK_MAX;
                  else if (pick < 5) dt = TickW'($urandom_range(255));
                  else dt = TickW'($urandom);
                  queue_command(OP_TICK, ModeW'($urandom), GaitW'($urandom), dt);
               end
            end
         end else if (kind < 60) begin
            queue_command(OP_REQUEST, $urandom_range(1) ? MODE_WALKING : MODE_STANDING,
                          GaitW'($urandom), TickW'($urandom));
            queue_op(OP_TICK);
            repeat ($urandom_range(1, 6))
               queue_op($urandom_range(1) ? OP_SET_GAIT : OP_NEXT_GAIT);
         end else if (kind < 75) begin
            queue_op(OP_ESTOP);
            repeat ($urandom_range(3))
               queue_op(OpW'($urandom_range(OP_NEXT_GAIT)));
            queue_op(OP_CLEAR);
            queue_op(OP_TICK);
         end else begin
            repeat ($urandom_range(1, 4))
               queue_op(OpW'($urandom_range(7)));
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_duration(1);
      queue_op(OP_UNUSED);
      queue_command(OP_REQUEST, MODE_INVALID, GaitW'($urandom), TickW'($urandom));
      queue_command(OP_SET_GAIT, ModeW'($urandom), GAIT_TROT, TickW'($urandom));
      queue_op(OP_NEXT_GAIT);
      queue_op(OP_CLEAR);
      queue_command(OP_REQUEST, MODE_PD, GaitW'($urandom), TickW'($urandom));
      queue_command(OP_TICK, ModeW'($urandom), GaitW'($urandom), '0);
      queue_command(OP_REQUEST, MODE_RECOVERY, GaitW'($urandom), TickW'($urandom));
      // Entering recovery counts this tick, so the one-microsecond duration completes at once.
      queue_command(OP_TICK, ModeW'($urandom), GaitW'($urandom), TICK_MAX);
      queue_command(OP_TICK, ModeW'($urandom), GaitW'($urandom), '0);
      queue_command(OP_REQUEST, MODE_WALKING, GaitW'($urandom), TickW'($urandom));
      queue_op(OP_TICK);
      repeat (4) queue_op(OP_NEXT_GAIT);
      queue_command(OP_SET_GAIT, ModeW'($urandom), GAIT_UNNAMED, TickW'($urandom));
      queue_op(OP_NEXT_GAIT);
      queue_command(OP_SET_GAIT, ModeW'($urandom), GAIT_STANCE, TickW'($urandom));
      queue_op(OP_ESTOP);
      queue_op(OP_ESTOP);
      queue_command(OP_REQUEST, MODE_EMERGENCY, GaitW'($urandom), TickW'($urandom));
      queue_op(OP_CLEAR);
      queue_op(OP_TICK);
      queue_command(OP_REQUEST, MODE_STANDING, GaitW'($urandom), TickW'($urandom));
      queue_op(OP_TICK);
      wait_drained();

      write_duration(CsrDataW'(RECOVERY_RESET));
      random_phase(500);
      wait_drained();

      write_duration(CsrDataW'(TIME_MAX));
      no_idle = 1'b1;
      random_phase(500);
      wait_drained();
      no_idle = 1'b0;

      write_duration($urandom_range(1, 200000));
      random_phase(700);
      wait_drained();

      repeat (10) @(posedge clock);
      if (expected_status.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_status.size()));
      if (mismatch_count == 0) begin
         $display("** robot_mode_supervisor: PASSED **");
      end else begin
         $display("** robot_mode_supervisor: FAILED **");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/rms_pkg.sv
rtl/rms_csr.sv
rtl/rms_step.sv
rtl/rms_outq.sv
rtl/robot_mode_supervisor.sv
verif/testbench.sv
